### src/u8d_pkg.sv
// Shared types for the UTF-8 to UCS-2 decoder.
`default_nettype none
package u8d_pkg;

  localparam int unsigned MaxUnits = 3;

  typedef enum logic [1:0] {
    PK_NONE     = 2'd0,
    PK_TWO      = 2'd1,
    PK_THREE    = 2'd2,
    PK_THREE_C1 = 2'd3
  } pend_kind_t;

  typedef struct packed {
    logic [1:0]                  count;
    logic [MaxUnits-1:0][15:0]   units;
    logic                        text_end;
  } job_t;

endpackage
`default_nettype wire

### src/u8d_front.sv
// Front end: accepts bytes, tracks open sequences, builds one job per byte.
`default_nettype none
module u8d_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    text_byte,
  output u8d_pkg::job_t      job,
  output logic               job_push
);

  u8d_pkg::pend_kind_t kind_r, kind_nxt;
  logic [7:0] lead_r, lead_nxt;
  logic [7:0] cont1_r, cont1_nxt;

  logic cont;
  logic fresh;
  logic is_two;
  logic is_three;

  assign cont     = (text_byte[7:6] == 2'b10);
  assign is_two   = (text_byte[7:5] == 3'b110);
  assign is_three = (text_byte[7:4] == 4'b1110);
  assign fresh    = !(cont && (kind_r != u8d_pkg::PK_NONE));

  // next state
  always_comb begin
    kind_nxt  = u8d_pkg::PK_NONE;
    lead_nxt  = lead_r;
    cont1_nxt = cont1_r;
    if ((kind_r == u8d_pkg::PK_THREE) && cont) begin
      kind_nxt  = u8d_pkg::PK_THREE_C1;
      cont1_nxt = text_byte;
    end else if (fresh) begin
      if (is_two) begin
        kind_nxt = u8d_pkg::PK_TWO;
        lead_nxt = text_byte;
      end else if (is_three) begin
        kind_nxt = u8d_pkg::PK_THREE;
        lead_nxt = text_byte;
      end
    end
  end

  // job contents
  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    job = '0;
    unique case (kind_r)
      u8d_pkg::PK_TWO: begin
        if (cont) begin
          job.units[n] = {5'd0, lead_r[4:0], text_byte[5:0]};
        end else begin
          job.units[n] = {8'd0, lead_r};
        end
        n = n + 2'd1;
      end
      u8d_pkg::PK_THREE: begin
        if (!cont) begin
          job.units[n] = {8'd0, lead_r};
          n = n + 2'd1;
        end
      end
      u8d_pkg::PK_THREE_C1: begin
        if (cont) begin
          job.units[n] = {lead_r[3:0], cont1_r[5:0], text_byte[5:0]};
          n = n + 2'd1;
        end else begin
          job.units[n] = {8'd0, lead_r};
          n = n + 2'd1;
          job.units[n] = {8'd0, cont1_r};
          n = n + 2'd1;
        end
      end
      u8d_pkg::PK_NONE: begin
      end
      default: begin
      end
    endcase
    if (fresh && !is_two && !is_three) begin
      job.units[n] = {8'd0, text_byte};
      job.text_end = (text_byte == 8'd0);
      n = n + 2'd1;
    end
    job.count = n;
  end

  assign job_push = accept && (job.count != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= u8d_pkg::PK_NONE;
      lead_r  <= 8'd0;
      cont1_r <= 8'd0;
    end else if (accept) begin
      kind_r  <= kind_nxt;
      lead_r  <= lead_nxt;
      cont1_r <= cont1_nxt;
    end
  end

endmodule
`default_nettype wire

### src/u8d_queue.sv
// Two-entry job queue between front and back end.
`default_nettype none
module u8d_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic          pop,
  input  wire u8d_pkg::job_t wr_job,
  output u8d_pkg::job_t      rd_job,
  output logic               full,
  output logic               empty
);

  u8d_pkg::job_t mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
    end
  end

endmodule
`default_nettype wire

### src/u8d_back.sv
// Back end: unpacks jobs into single code units behind an output register.
`default_nettype none
module u8d_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire u8d_pkg::job_t job,
  input  wire logic          job_avail,
  output logic               job_pop,
  input  wire logic          out_pop,
  output logic               out_empty,
  output logic [15:0]        out_code_unit,
  output logic               out_run_last,
  output logic               out_text_end
);

  logic        valid_r;
  logic [1:0]  idx_r;
  logic [15:0] unit_r;
  logic        last_r, end_r;
  logic        advance, is_last, load;

  assign advance = !valid_r || out_pop;
  assign load    = advance && job_avail;
  assign is_last = (idx_r == (job.count - 2'd1));
  assign job_pop = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (advance) begin
      valid_r <= job_avail;
      if (load) begin
        idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_r <= job.units[idx_r];
      last_r <= is_last;
      end_r  <= is_last && job.text_end;
    end
  end

  assign out_empty     = !valid_r;
  assign out_code_unit = unit_r;
  assign out_run_last  = last_r;
  assign out_text_end  = end_r;

endmodule
`default_nettype wire

### src/utf8_to_ucs2_decoder.sv
// Top level of the UTF-8 to UCS-2 decoder.
`default_nettype none
// Takes one UTF-8 byte per clock while in_full is low and yields 16-bit code
// units. Each byte is classified and, if it gives one to three units, becomes
// a job in a two-entry queue; the back end sends out one unit per cycle while
// out_pop is held, through an output register, so bytes giving at most one
// unit stream at one per clock and a byte that flushes buffered bytes gives
// its units in turn while more bytes fill the queue. Units pass through the
// queue and the output register. A zero byte ends the text and yields unit 0 with text_end set.
module utf8_to_ucs2_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_text_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [15:0]      out_code_unit,
  output logic             out_run_last,
  output logic             out_text_end
);

  u8d_pkg::job_t   fr_job, q_job;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  logic            accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  u8d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .text_byte (in_text_byte),
    .job       (fr_job),
    .job_push  (q_push)
  );

  u8d_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .pop    (q_pop),
    .wr_job (fr_job),
    .rd_job (q_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  u8d_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job           (q_job),
    .job_avail     (!q_empty),
    .job_pop       (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_code_unit (out_code_unit),
    .out_run_last  (out_run_last),
    .out_text_end  (out_text_end)
  );

  a_end_is_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_text_end) |-> (out_run_last && out_code_unit == 16'd0))
    else $error("text end not on a last zero unit");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty)
    else $error("output not empty after reset");

  a_no_empty_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (fr_job.count != 2'd0 && !q_full))
    else $error("bad job pushed");

  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

endmodule
`default_nettype wire
